/* src/assert_macros.svh */
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CBP_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CBP_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cbp_pkg.sv */
`default_nettype none

package cbp_pkg;

	// configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CMP_W     = CFG_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;
	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int MIN_DIM          = 2;

	// beat fields
	localparam int PLANE_W  = 2;
	localparam int COL_W    = 12;
	localparam int LINE_W   = 12;
	localparam int FRAME_W  = 32;
	localparam int SAMPLE_W = 8;

	typedef enum logic [PLANE_W-1:0] {
		PLANE_Y = 2'd0,
		PLANE_U = 2'd1,
		PLANE_V = 2'd2
	} plane_t;

	// bar pattern
	localparam int BAR_W = 3;
	localparam logic [SAMPLE_W-1:0] BAR_Y [8] = '{8'd255, 8'd226, 8'd179, 8'd150,
		8'd105, 8'd76, 8'd29, 8'd0};
	localparam logic [SAMPLE_W-1:0] BAR_U [8] = '{8'd128, 8'd0, 8'd171, 8'd44,
		8'd212, 8'd85, 8'd255, 8'd128};
	localparam logic [SAMPLE_W-1:0] BAR_V [8] = '{8'd128, 8'd149, 8'd0, 8'd21,
		8'd235, 8'd255, 8'd107, 8'd128};
	localparam logic [SAMPLE_W-1:0] MARKER_LUMA = 8'd255;
	localparam logic [SAMPLE_W-1:0] NO_SAMPLE   = 8'd0;

	// h/10 as (h * 6554) >> 16, exact for h up to 8192
	localparam int SIDE_RECIP = 6554;
	localparam int SIDE_SHIFT = 16;
	localparam int RECIP_W    = 13;

endpackage

`default_nettype wire

/* src/cbp_rem_pipe.sv */
`default_nettype none

// Pipelined restoring divider: one dividend bit per stage, several lanes
// sharing one valid and one sideband. Divisors must stay static while beats
// are in flight (the divider does not enforce it), so they are not carried along.
module cbp_rem_pipe #(
	parameter int NL = 1,
	parameter int AW = 8,
	parameter int DW = 8,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [AW-1:0] in_a [NL],
	input  logic [DW-1:0] d [NL],
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [DW-1:0] out_rem [NL],
	output logic [AW-1:0] out_quo [NL],
	output logic [PW-1:0] out_pay
);

	logic          vld_s [AW];
	logic [AW-1:0] dvd_s [AW][NL];
	logic [DW-1:0] rem_s [AW][NL];
	logic [AW-1:0] quo_s [AW][NL];
	logic [PW-1:0] pay_s [AW];

	for (genvar k = 0; k < AW; k++) begin : g_stage
		logic          v_in;
		logic [PW-1:0] p_in;
		logic [AW-1:0] a_in [NL];
		logic [DW-1:0] r_in [NL];
		logic [AW-1:0] q_in [NL];
		logic [DW-1:0] r_nx [NL];
		logic [AW-1:0] q_nx [NL];

		// stage inputs
		if (k == 0) begin : g_head
			assign v_in = in_valid;
			assign p_in = in_pay;
			for (genvar l = 0; l < NL; l++) begin : g_lane
				assign a_in[l] = in_a[l];
				assign r_in[l] = '0;
				assign q_in[l] = '0;
			end
		end else begin : g_body
			assign v_in = vld_s[k-1];
			assign p_in = pay_s[k-1];
			for (genvar l = 0; l < NL; l++) begin : g_lane
				assign a_in[l] = dvd_s[k-1][l];
				assign r_in[l] = rem_s[k-1][l];
				assign q_in[l] = quo_s[k-1][l];
			end
		end

		// shift in next dividend bit, subtract if it fits
		for (genvar l = 0; l < NL; l++) begin : g_step
			logic [DW:0] trial;
			logic        take;
			assign trial   = {r_in[l], a_in[l][AW-1-k]};
			assign take    = trial >= {1'b0, d[l]};
			assign r_nx[l] = take ? DW'(trial - {1'b0, d[l]}) : DW'(trial);
			assign q_nx[l] = AW'({q_in[l], take});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[k] <= p_in;
				dvd_s[k] <= a_in;
				rem_s[k] <= r_nx;
				quo_s[k] <= q_nx;
			end
		end
	end

	assign out_valid = vld_s[AW-1];
	assign out_rem   = rem_s[AW-1];
	assign out_quo   = quo_s[AW-1];
	assign out_pay   = pay_s[AW-1];

endmodule

`default_nettype wire

/* src/cbp_out_skid.sv */
`default_nettype none

// Two-entry result buffer: keeps the pipeline moving while a beat waits
// and cuts the path from the downstream ready to the upstream ready.
module cbp_out_skid #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam logic [1:0] DEPTH = 2'd2;

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign pop = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign full      = cnt_q == DEPTH;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rd_q];

endmodule

`default_nettype wire

/* src/color_bar_pattern_generator_unit.sv */
// Path: capture, frame divider, scroll and marker edges, hit test, bar divider, lookup, buffer.
// Throughput: one beat per cycle unless the result buffer is full or a register
//   write is settling; each divider stage retires one dividend bit.
// Reset (arst_n, async low) empties the pipeline and loads 640x480; in_ready
//   stays low after reset and after each register write while the derived
//   geometry (clamped size, marker side, wrap ranges) settles.
`default_nettype none

module color_bar_pattern_generator_unit #(
	parameter int MAX_WIDTH  = cbp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cbp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cbp_pkg::PLANE_W-1:0]    plane,
	input  logic [cbp_pkg::COL_W-1:0]      column,
	input  logic [cbp_pkg::LINE_W-1:0]     line,
	input  logic [cbp_pkg::FRAME_W-1:0]    frame_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cbp_pkg::SAMPLE_W-1:0]   sample
);

	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int FDW    = (WW > HW) ? WW : HW;
	localparam int FAW    = cbp_pkg::FRAME_W + 3;
	localparam int XW     = cbp_pkg::COL_W + 1;
	localparam int SUMW   = ((WW > XW) ? WW : XW) + 1;
	localparam int BAW    = SUMW + cbp_pkg::BAR_W;
	localparam int PXW    = (cbp_pkg::COL_W > cbp_pkg::LINE_W) ? cbp_pkg::COL_W
		: cbp_pkg::LINE_W;
	localparam int MKW    = ((FDW > PXW) ? FDW : PXW) + 1;
	localparam int PRODW  = HW + cbp_pkg::RECIP_W + 1;
	localparam logic [1:0] SETTLE = 2'd3;

	localparam int FR_LANES   = 3;
	localparam int LANE_SHIFT = 0;
	localparam int LANE_BX    = 1;
	localparam int LANE_BY    = 2;

	typedef struct packed {
		logic [cbp_pkg::PLANE_W-1:0] plane;
		logic [cbp_pkg::COL_W-1:0]   col;
		logic [cbp_pkg::LINE_W-1:0]  line;
	} pix_t;

	typedef struct packed {
		logic [cbp_pkg::PLANE_W-1:0] plane;
		logic                        hit;
	} bar_tag_t;

	// ---------------------------------------------------------------
	// configuration registers and derived geometry
	logic [cbp_pkg::CFG_W-1:0] fw_q;
	logic [cbp_pkg::CFG_W-1:0] fh_q;
	logic [1:0]                settle_q;
	logic [WW-1:0]             w_q;
	logic [HW-1:0]             h_q;
	logic [HW-1:0]             side_q;
	logic                      mk_en_q;
	logic [FDW-1:0]            dx_q;
	logic [FDW-1:0]            dy_q;

	logic [WW-1:0]    w_clamp;
	logic [HW-1:0]    h_clamp;
	logic [PRODW-1:0] side_prod;
	logic             mk_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= cbp_pkg::CFG_W'(cbp_pkg::RST_FRAME_WIDTH);
			fh_q     <= cbp_pkg::CFG_W'(cbp_pkg::RST_FRAME_HEIGHT);
			settle_q <= SETTLE;
		end else if (cfg_write) begin
			settle_q <= SETTLE;
			unique case (cfg_index)
				cbp_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg_data;
				end
				cbp_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data;
				end
			endcase
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// clamp to [2, MAX]
	always_comb begin
		if ({1'b0, fw_q} < cbp_pkg::CMP_W'(cbp_pkg::MIN_DIM)) begin
			w_clamp = WW'(cbp_pkg::MIN_DIM);
		end else if ({1'b0, fw_q} > cbp_pkg::CMP_W'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(fw_q);
		end
		if ({1'b0, fh_q} < cbp_pkg::CMP_W'(cbp_pkg::MIN_DIM)) begin
			h_clamp = HW'(cbp_pkg::MIN_DIM);
		end else if ({1'b0, fh_q} > cbp_pkg::CMP_W'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(fh_q);
		end
	end

	assign side_prod = PRODW'(h_q) * PRODW'(cbp_pkg::SIDE_RECIP);
	assign mk_en     = (side_q != '0) && (FDW'(side_q) < FDW'(w_q)) && (side_q < h_q);

	// three register levels: clamp, side, wrap ranges
	always_ff @(posedge clk) begin
		w_q     <= w_clamp;
		h_q     <= h_clamp;
		side_q  <= HW'(side_prod >> cbp_pkg::SIDE_SHIFT);
		mk_en_q <= mk_en;
		dx_q    <= mk_en ? FDW'(w_q) - FDW'(side_q) : FDW'(1);
		dy_q    <= mk_en ? FDW'(h_q) - FDW'(side_q) : FDW'(1);
	end

	// ---------------------------------------------------------------
	// flow control: every stage advances unless the result buffer is full
	logic en;
	logic skid_full;
	logic accept;

	assign en       = !skid_full;
	assign in_ready = en && (settle_q == 2'd0);
	assign accept   = in_valid && in_ready;

	// ---------------------------------------------------------------
	// stage 1: capture beat, form frame multiples
	logic           vld_s1;
	pix_t           pix_s1;
	logic [FAW-1:0] a_shift_s1;
	logic [FAW-1:0] a_bx_s1;
	logic [FAW-1:0] a_by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1     <= '{plane: plane, col: column, line: line};
			a_shift_s1 <= {frame_number, 3'b000};
			a_bx_s1    <= {frame_number, 3'b000} - FAW'(frame_number);
			a_by_s1    <= FAW'({frame_number, 1'b0}) + FAW'(frame_number);
		end
	end

	// ---------------------------------------------------------------
	// frame remainders: scroll shift and marker position
	logic [FAW-1:0] fr_a [FR_LANES];
	logic [FDW-1:0] fr_d [FR_LANES];
	logic [FDW-1:0] fr_rem [FR_LANES];
	logic           fr_vld;
	pix_t           fr_pix;

	assign fr_a[LANE_SHIFT] = a_shift_s1;
	assign fr_a[LANE_BX]    = a_bx_s1;
	assign fr_a[LANE_BY]    = a_by_s1;
	assign fr_d[LANE_SHIFT] = FDW'(w_q);
	assign fr_d[LANE_BX]    = dx_q;
	assign fr_d[LANE_BY]    = dy_q;

	cbp_rem_pipe #(
		.NL(FR_LANES),
		.AW(FAW),
		.DW(FDW),
		.PW($bits(pix_t))
	) u_frame_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.in_a     (fr_a),
		.d        (fr_d),
		.in_pay   (pix_s1),
		.out_valid(fr_vld),
		.out_rem  (fr_rem),
		.out_quo  (),
		.out_pay  (fr_pix)
	);

	// ---------------------------------------------------------------
	// stage 2: scrolled column, marker box edges
	logic            vld_s2;
	pix_t            pix_s2;
	logic [SUMW-1:0] sum_s2;
	logic [MKW-1:0]  bx_s2;
	logic [MKW-1:0]  bx_end_s2;
	logic [MKW-1:0]  by_s2;
	logic [MKW-1:0]  by_end_s2;
	logic [XW-1:0]   xpos;

	assign xpos = (fr_pix.plane == cbp_pkg::PLANE_Y) ? XW'(fr_pix.col) : {fr_pix.col, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= fr_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2    <= fr_pix;
			sum_s2    <= SUMW'(xpos) + SUMW'(fr_rem[LANE_SHIFT]);
			bx_s2     <= MKW'(fr_rem[LANE_BX]);
			bx_end_s2 <= MKW'(fr_rem[LANE_BX]) + MKW'(side_q);
			by_s2     <= MKW'(fr_rem[LANE_BY]);
			by_end_s2 <= MKW'(fr_rem[LANE_BY]) + MKW'(side_q);
		end
	end

	// ---------------------------------------------------------------
	// stage 3: marker hit test
	logic            vld_s3;
	logic [SUMW-1:0] sum_s3;
	bar_tag_t        tag_s3;
	logic            hit;

	assign hit = mk_en_q && (pix_s2.plane == cbp_pkg::PLANE_Y)
		&& (MKW'(pix_s2.col) >= bx_s2) && (MKW'(pix_s2.col) < bx_end_s2)
		&& (MKW'(pix_s2.line) >= by_s2) && (MKW'(pix_s2.line) < by_end_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_s2;
			tag_s3 <= '{plane: pix_s2.plane, hit: hit};
		end
	end

	// ---------------------------------------------------------------
	// bar index: low quotient bits of (scrolled x * 8) / width
	logic [BAW-1:0] bar_a [1];
	logic [WW-1:0]  bar_d [1];
	logic [BAW-1:0] bar_quo [1];
	logic           bar_vld;
	bar_tag_t       bar_tag;

	assign bar_a[0] = {sum_s3, {cbp_pkg::BAR_W{1'b0}}};
	assign bar_d[0] = w_q;

	cbp_rem_pipe #(
		.NL(1),
		.AW(BAW),
		.DW(WW),
		.PW($bits(bar_tag_t))
	) u_bar_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_a     (bar_a),
		.d        (bar_d),
		.in_pay   (tag_s3),
		.out_valid(bar_vld),
		.out_rem  (),
		.out_quo  (bar_quo),
		.out_pay  (bar_tag)
	);

	// ---------------------------------------------------------------
	// stage 4: sample lookup
	logic                          vld_s4;
	logic [cbp_pkg::SAMPLE_W-1:0]  sample_s4;
	logic [cbp_pkg::SAMPLE_W-1:0]  sample_nx;
	logic [cbp_pkg::BAR_W-1:0]     bar_idx;

	assign bar_idx = bar_quo[0][cbp_pkg::BAR_W-1:0];

	always_comb begin
		case (bar_tag.plane)
			cbp_pkg::PLANE_Y: begin
				sample_nx = bar_tag.hit ? cbp_pkg::MARKER_LUMA : cbp_pkg::BAR_Y[bar_idx];
			end
			cbp_pkg::PLANE_U: begin
				sample_nx = cbp_pkg::BAR_U[bar_idx];
			end
			cbp_pkg::PLANE_V: begin
				sample_nx = cbp_pkg::BAR_V[bar_idx];
			end
			default: begin
				sample_nx = cbp_pkg::NO_SAMPLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= bar_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s4 <= sample_nx;
		end
	end

	// ---------------------------------------------------------------
	// result buffer
	cbp_out_skid #(
		.W(cbp_pkg::SAMPLE_W)
	) u_out_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en && vld_s4),
		.push_data(sample_s4),
		.full     (skid_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (sample)
	);

endmodule

`default_nettype wire

/* src/cbp_checker.sv */
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the colour-bar generator.
module cbp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cfg_write,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [cbp_pkg::SAMPLE_W-1:0] sample
);

	// no beat taken while the new geometry settles
	`CBP_ASSERT(a_cfg_settle, clk, arst_n, cfg_write |=> !in_ready, "beat accepted after write")

	// pipeline and buffer come out of reset empty and closed
	`CBP_ASSERT_ALWAYS(a_reset_quiet, clk, $rose(arst_n) |-> !out_valid && !in_ready, "not idle after reset")

	// a stalled result beat holds
	`CBP_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(sample), "result beat changed while stalled")

endmodule

bind color_bar_pattern_generator_unit cbp_checker u_cbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_write(cfg_write),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.sample   (sample)
);

`default_nettype wire

/* tb/cbp_sample_checker.sv */
`default_nettype none

module cbp_sample_checker
	import cbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [PLANE_W-1:0]    plane,
	input  logic [COL_W-1:0]      column,
	input  logic [LINE_W-1:0]     line,
	input  logic [FRAME_W-1:0]    frame_number,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	output int                    mismatch_count,
	output int                    samples_owed
);

	localparam longint unsigned MAX_W = DEF_MAX_WIDTH;
	localparam longint unsigned MAX_H = DEF_MAX_HEIGHT;

	typedef struct {
		logic [PLANE_W-1:0]  plane;
		logic [COL_W-1:0]    column;
		logic [LINE_W-1:0]   line;
		logic [FRAME_W-1:0]  frame;
		logic [SAMPLE_W-1:0] sample;
	} pixel_req_t;

	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	pixel_req_t       awaited_pixels[$];
	pixel_req_t       head;
	int               fails = 0;
	int               backlog = 0;

	assign mismatch_count = fails;
	assign samples_owed   = backlog;

	// sample of the scrolling bars, with the moving white square on luma
	function automatic logic [SAMPLE_W-1:0] bar_sample_at(
		input logic [CFG_W-1:0]   wreg,
		input logic [CFG_W-1:0]   hreg,
		input logic [PLANE_W-1:0] pl,
		input logic [COL_W-1:0]   col,
		input logic [LINE_W-1:0]  row,
		input logic [FRAME_W-1:0] fr
	);
		longint unsigned w, h, shift, side, bx, by, x, cx, cy;
		logic [BAR_W-1:0] bar;
		logic [SAMPLE_W-1:0] s;
		w = (wreg < MIN_DIM) ? MIN_DIM : (wreg > MAX_W) ? MAX_W : wreg;
		h = (hreg < MIN_DIM) ? MIN_DIM : (hreg > MAX_H) ? MAX_H : hreg;
		cx = col;
		cy = row;
		shift = (longint'(fr) * 8) % w;
		// chroma column c sits on luma column 2c
		x = (pl == PLANE_Y) ? cx : cx * 2;
		bar = BAR_W'((((x + shift) % w) * 8) / w);
		case (pl)
			PLANE_Y: begin
				s = BAR_Y[bar];
				side = h / 10;
				if (side != 0 && side < w && side < h) begin
					bx = (longint'(fr) * 7) % (w - side);
					by = (longint'(fr) * 3) % (h - side);
					if (cx >= bx && cx < bx + side && cy >= by && cy < by + side)
						s = MARKER_LUMA;
				end
			end
			PLANE_U: s = BAR_U[bar];
			PLANE_V: s = BAR_V[bar];
			default: s = NO_SAMPLE;
		endcase
		return s;
	endfunction

	// shadow copy of the frame size registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= CFG_W'(RST_FRAME_WIDTH);
			height_reg <= CFG_W'(RST_FRAME_HEIGHT);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_reg  <= cfg_data;
				REG_FRAME_HEIGHT: height_reg <= cfg_data;
				default: ;
			endcase
		end
	end

	// match result beats against requests in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_pixels.size() == 0) begin
					$display("%0t: sample beat with none owed: expected none, got %0d",
						$time, sample);
					fails++;
				end else begin
					head = awaited_pixels.pop_front();
					if (sample !== head.sample) begin
						$display("%0t: sample (plane %0d col %0d line %0d frame %0d): expected %0d, got %0d",
							$time, head.plane, head.column, head.line, head.frame,
							head.sample, sample);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				head.plane  = plane;
				head.column = column;
				head.line   = line;
				head.frame  = frame_number;
				head.sample = bar_sample_at(width_reg, height_reg, plane, column, line,
					frame_number);
				awaited_pixels.push_back(head);
			end
			backlog = awaited_pixels.size();
		end
	end

endmodule

`default_nettype wire

/* tb/color_bar_pattern_generator_unit_tb.sv */
`default_nettype none

module color_bar_pattern_generator_unit_tb;
	import cbp_pkg::*;

	localparam logic [PLANE_W-1:0] PLANE_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_STALL   = 400;
	localparam int BEATS_PER_SET = 42;
	// more beats than the pipeline and result buffer hold, so input stalls
	localparam int STALL_SET_BEATS = 100;
	localparam int N_SET = 9;
	// frame sizes per setting: minimum, maximum, clamped high, clamped low,
	// odd, marker side zero, marker as wide as the frame, full HD, tiny marker
	localparam int SET_W [N_SET] = '{2, 4096, 8191, 0, 641, 100, 20, 1920, 17};
	localparam int SET_H [N_SET] = '{2, 4096, 8191, 1, 37, 9, 200, 1080, 11};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PLANE_W-1:0]    plane;
	logic [COL_W-1:0]      column;
	logic [LINE_W-1:0]     line;
	logic [FRAME_W-1:0]    frame_number;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SAMPLE_W-1:0]   sample;

	int   send_idle_pct;
	int   recv_idle_pct;
	logic stall_req;
	int   stall_left = 0;
	logic stall_taken = 1'b0;
	int   cycles = 0;
	int   errors;
	int   owed;
	int   cur_w;
	int   cur_h;

	always #1 clk = ~clk;

	color_bar_pattern_generator_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.plane        (plane),
		.column       (column),
		.line         (line),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample)
	);

	cbp_sample_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.plane          (plane),
		.column         (column),
		.line           (line),
		.frame_number   (frame_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.mismatch_count (errors),
		.samples_owed   (owed)
	);

	// receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_req && !stall_taken) begin
			stall_left  = LONG_STALL;
			stall_taken = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("color_bar_pattern_generator_unit_tb: errors");
			$finish;
		end
	end

	task automatic send_beat(
		input logic [PLANE_W-1:0] pl,
		input logic [COL_W-1:0]   col,
		input logic [LINE_W-1:0]  row,
		input logic [FRAME_W-1:0] fr
	);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		plane        <= pl;
		column       <= col;
		line         <= row;
		frame_number <= fr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// random request, mostly inside the plane, part of luma aimed at the square
	task automatic send_random();
		logic [PLANE_W-1:0] pl;
		logic [FRAME_W-1:0] fr;
		int w, h, side, pick, c, r;
		longint bx, by;
		w = (cur_w < MIN_DIM) ? MIN_DIM : (cur_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_w;
		h = (cur_h < MIN_DIM) ? MIN_DIM : (cur_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_h;
		side = h / 10;
		pick = $urandom_range(99);
		pl = (pick < 50) ? PLANE_Y : (pick < 72) ? PLANE_U : (pick < 94) ? PLANE_V : PLANE_UNUSED;
		case ($urandom_range(3))
			0:       fr = $urandom;
			1:       fr = $urandom_range(2000);
			2:       fr = 32'hFFFF_FFFF - $urandom_range(50);
			default: fr = $urandom_range(100000);
		endcase
		if ($urandom_range(9) < 8) begin
			c = $urandom_range((pl == PLANE_Y) ? w - 1 : w / 2 - 1);
			r = $urandom_range((pl == PLANE_Y) ? h - 1 : h / 2 - 1);
		end else begin
			c = $urandom_range(4095);
			r = $urandom_range(4095);
		end
		if (pl == PLANE_Y && side != 0 && side < w && side < h && $urandom_range(2) == 0) begin
			bx = (longint'(fr) * 7) % (w - side);
			by = (longint'(fr) * 3) % (h - side);
			c = int'(bx) + $urandom_range(side + 1) - 1;
			r = int'(by) + $urandom_range(side + 1) - 1;
			if (c < 0) c = 0;
			if (r < 0) r = 0;
		end
		send_beat(pl, COL_W'(c), LINE_W'(r), fr);
	endtask

	// drop valid and let every owed sample come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_FRAME_WIDTH;
		cfg_data      = '0;
		in_valid      = 1'b0;
		plane         = PLANE_Y;
		column        = '0;
		line          = '0;
		frame_number  = '0;
		send_idle_pct = 11;
		recv_idle_pct = 74;
		stall_req     = 1'b0;
		cur_w         = RST_FRAME_WIDTH;
		cur_h         = RST_FRAME_HEIGHT;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed beats at the reset size, 640x480 with a 48-pixel square
		send_beat(PLANE_Y, 0, 0, 0);
		send_beat(PLANE_Y, 47, 47, 0);
		send_beat(PLANE_Y, 48, 47, 0);
		send_beat(PLANE_Y, 47, 48, 0);
		for (int k = 0; k < 8; k++)
			send_beat(PLANE_Y, COL_W'(k * 80), 200, 0);
		send_beat(PLANE_Y, 639, 479, 0);
		send_beat(PLANE_Y, 7, 3, 1);
		send_beat(PLANE_Y, 6, 3, 1);
		// scroll of 640 wraps back to no shift
		send_beat(PLANE_Y, 0, 200, 80);
		send_beat(PLANE_Y, 4095, 4095, 32'hFFFF_FFFF);
		send_beat(PLANE_U, 0, 0, 0);
		send_beat(PLANE_U, 319, 239, 3);
		send_beat(PLANE_V, 160, 4095, 0);
		send_beat(PLANE_V, 4095, 0, 32'hFFFF_FFFF);
		send_beat(PLANE_UNUSED, 5, 5, 0);

		// random beats over a range of frame sizes and idling patterns
		for (int s = 0; s < N_SET; s++) begin
			if (s == 3) begin
				send_idle_pct = 74;
				recv_idle_pct = 11;
			end
			if (s == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_idle();
			write_reg(REG_FRAME_WIDTH, SET_W[s]);
			write_reg(REG_FRAME_HEIGHT, SET_H[s]);
			cur_w = SET_W[s];
			cur_h = SET_H[s];
			// long output hold-off while the sender keeps pushing
			if (s == 6)
				stall_req = 1'b1;
			repeat ((s == 6) ? STALL_SET_BEATS : BEATS_PER_SET) send_random();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("color_bar_pattern_generator_unit_tb: clean");
		else
			$display("color_bar_pattern_generator_unit_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
